[rtl/ibs_pkg.sv]
// Shared constants and types for the integer batch sorter.
// Used by the channel interfaces, the cell chain, the scan network and the top level.
// Depends on nothing.
package ibs_pkg;

    localparam int MAX_ITEMS   = 64;
    localparam int VALUE_W     = 32;
    localparam int COUNT_W     = $clog2(MAX_ITEMS + 1);
    localparam int SCAN_LEVELS = $clog2(MAX_ITEMS);

    typedef logic signed [VALUE_W-1:0] value_t;
    typedef logic [COUNT_W-1:0]        count_t;

    // Per-cell load selection; take_right wins over take_left, take_left over load_key.
    typedef struct packed {
        logic take_right;
        logic take_left;
        logic load_key;
    } cell_ctrl_t;

endpackage

[rtl/ibs_if.sv]
// Valid/ready channel interfaces of the integer batch sorter: input samples,
// sorted results and the order configuration write channel.
// Depends on ibs_pkg.
interface ibs_in_if;
    logic           valid;
    logic           ready;
    ibs_pkg::value_t sample_value;
    logic           batch_end;

    modport source (output valid, output sample_value, output batch_end, input ready);
    modport sink   (input valid, input sample_value, input batch_end, output ready);
endinterface

interface ibs_out_if;
    logic           valid;
    logic           ready;
    ibs_pkg::value_t sorted_value;
    logic           final_of_run;
    logic           overflow_seen;

    modport source (output valid, output sorted_value, output final_of_run,
                    output overflow_seen, input ready);
    modport sink   (input valid, input sorted_value, input final_of_run,
                    input overflow_seen, output ready);
endinterface

interface ibs_cfg_if;
    logic valid;
    logic ready;
    logic ascending_order;

    modport source (output valid, output ascending_order, input ready);
    modport sink   (input valid, input ascending_order, output ready);
endinterface

[rtl/integer_batch_sorter_unit.sv]
// Integer batch sorter: signed 32-bit samples are inserted into a chain of
// 64 cells at their sorted place, one sample beat per cycle. The beat marked
// batch_end is inserted as well and starts emission: the held values leave
// from the head of the chain, one result beat per cycle while the sink is
// ready, and no sample is taken until the batch has drained. The chain
// shifts one place per emitted beat. Samples beyond 64 are dropped and every
// result of that batch carries overflow_seen. ascending_order (reset 1)
// selects smallest first.
// Depends on ibs_pkg, ibs_if, ibs_cell and ibs_scan.
module integer_batch_sorter_unit (
    input logic       clk,
    input logic       rst_n,
    ibs_in_if.sink    sample,
    ibs_out_if.source result,
    ibs_cfg_if.sink   cfg
);

    localparam int N = ibs_pkg::MAX_ITEMS;

    ibs_pkg::count_t count_reg;
    ibs_pkg::count_t count_next;
    logic            drain_reg;
    logic            drain_next;
    logic            dropped_reg;
    logic            dropped_next;
    logic            asc_reg;
    logic            out_valid_reg;
    ibs_pkg::value_t out_value_reg;
    logic            out_final_reg;
    logic            out_ovf_reg;

    ibs_pkg::value_t     cell_val [N];
    logic [N-1:0]        goes_after;
    logic [N-1:0]        move_ok;
    logic [N-1:0]        suffix;
    ibs_pkg::cell_ctrl_t ctrl [N];

    logic accept;
    logic full;
    logic insert;
    logic out_load;
    logic last_out;

    assign accept   = sample.valid && sample.ready;
    assign full     = (count_reg == ibs_pkg::COUNT_W'(N));
    assign insert   = accept && !full;
    assign out_load = drain_reg && (!out_valid_reg || result.ready);
    assign last_out = (count_reg == ibs_pkg::COUNT_W'(1));

    assign sample.ready = !drain_reg;
    assign cfg.ready    = 1'b1;

    assign result.valid         = out_valid_reg;
    assign result.sorted_value  = out_value_reg;
    assign result.final_of_run  = out_final_reg;
    assign result.overflow_seen = out_ovf_reg;

    generate
        for (genvar i = 0; i < N; i++)
        begin : g_cell
            // An empty cell always makes room; a held one only if it goes after the key.
            assign move_ok[i] = (ibs_pkg::COUNT_W'(i) >= count_reg) || goes_after[i];

            if (i == 0)
            begin : g_head
                assign ctrl[i].take_left = 1'b0;
                assign ctrl[i].load_key  = insert && suffix[i];
            end
            else
            begin : g_body
                assign ctrl[i].take_left = insert && suffix[i-1];
                assign ctrl[i].load_key  = insert && suffix[i] && !suffix[i-1];
            end
            assign ctrl[i].take_right = out_load;

            ibs_cell u_cell (
                .clk         (clk),
                .ctrl        (ctrl[i]),
                .asc         (asc_reg),
                .key         (sample.sample_value),
                .left_value  (cell_val[(i == 0) ? 0 : i - 1]),
                .right_value (cell_val[(i == N - 1) ? i : i + 1]),
                .value       (cell_val[i]),
                .goes_after  (goes_after[i])
            );
        end
    endgenerate

    ibs_scan u_scan (
        .move_ok (move_ok),
        .suffix  (suffix)
    );

    always_comb
    begin
        count_next   = count_reg;
        drain_next   = drain_reg;
        dropped_next = dropped_reg;
        if (insert)
        begin
            count_next = count_reg + ibs_pkg::COUNT_W'(1);
        end
        else if (out_load)
        begin
            count_next = count_reg - ibs_pkg::COUNT_W'(1);
        end
        if (accept && full)
        begin
            dropped_next = 1'b1;
        end
        if (accept && sample.batch_end)
        begin
            drain_next = 1'b1;
        end
        if (out_load && last_out)
        begin
            drain_next   = 1'b0;
            dropped_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            drain_reg     <= 1'b0;
            dropped_reg   <= 1'b0;
            asc_reg       <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg   <= count_next;
            drain_reg   <= drain_next;
            dropped_reg <= dropped_next;
            if (cfg.valid && cfg.ready)
            begin
                asc_reg <= cfg.ascending_order;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_value_reg <= cell_val[0];
            out_final_reg <= last_out;
            out_ovf_reg   <= dropped_reg;
        end
    end

endmodule

[rtl/ibs_cell.sv]
// One cell of the sorting chain: holds one value, compares it with the
// broadcast key and loads from its neighbors or the key as told.
// Depends on ibs_pkg.
module ibs_cell (
    input  logic                clk,
    input  ibs_pkg::cell_ctrl_t ctrl,
    input  logic                asc,
    input  ibs_pkg::value_t     key,
    input  ibs_pkg::value_t     left_value,
    input  ibs_pkg::value_t     right_value,
    output ibs_pkg::value_t     value,
    output logic                goes_after
);

    ibs_pkg::value_t value_reg;
    ibs_pkg::value_t value_next;

    // Strict compare, so a new value lands after held values equal to it.
    assign goes_after = asc ? (value_reg > key) : (value_reg < key);
    assign value      = value_reg;

    always_comb
    begin
        if (ctrl.take_right)
        begin
            value_next = right_value;
        end
        else if (ctrl.take_left)
        begin
            value_next = left_value;
        end
        else if (ctrl.load_key)
        begin
            value_next = key;
        end
        else
        begin
            value_next = value_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

endmodule

[rtl/ibs_scan.sv]
// Suffix-AND network over the cells: bit i is set when every cell from i to
// the end of the chain can move up to make room for the key.
// Depends on ibs_pkg.
module ibs_scan (
    input  logic [ibs_pkg::MAX_ITEMS-1:0] move_ok,
    output logic [ibs_pkg::MAX_ITEMS-1:0] suffix
);

    logic [ibs_pkg::MAX_ITEMS-1:0] lvl [ibs_pkg::SCAN_LEVELS+1];

    always_comb
    begin
        lvl[0] = move_ok;
        for (int k = 0; k < ibs_pkg::SCAN_LEVELS; k++)
        begin
            for (int i = 0; i < ibs_pkg::MAX_ITEMS; i++)
            begin
                if (i + (1 << k) < ibs_pkg::MAX_ITEMS)
                begin
                    lvl[k+1][i] = lvl[k][i] & lvl[k][i + (1 << k)];
                end
                else
                begin
                    lvl[k+1][i] = lvl[k][i];
                end
            end
        end
    end

    assign suffix = lvl[ibs_pkg::SCAN_LEVELS];

endmodule

[bench/integer_batch_sorter_unit_test.sv]
// Self-checking bench for integer_batch_sorter_unit: batches of signed samples are fed in,
// and every sorted result beat is checked against a predicted insertion-sorted store.
// Depends on ibs_pkg, the ibs channel interfaces and the top level.
`timescale 1ns / 1ps

typedef struct {
    ibs_pkg::value_t value;
    logic            final_of_run;
    logic            overflow_seen;
} sorted_beat_t;

class batch_sort_scoreboard;
    ibs_pkg::value_t held_values[ibs_pkg::MAX_ITEMS];
    int              held_count;
    bit              dropped;
    bit              ascending;
    sorted_beat_t    pending_sorted[$];
    int              errors;

    function new();
        held_count = 0;
        dropped    = 1'b0;
        ascending  = 1'b1;
        errors     = 0;
    endfunction

    function void set_order(bit asc);
        ascending = asc;
    endfunction

    function int pending();
        return pending_sorted.size();
    endfunction

    // Insert like the store does, then on batch_end release the whole batch in store order.
    function void note_sample(ibs_pkg::value_t v, bit last);
        int pos;
        sorted_beat_t beat;
        if (held_count >= ibs_pkg::MAX_ITEMS)
        begin
            dropped = 1'b1;
        end
        else
        begin
            pos = held_count;
            // Equal values stay ahead of the new one, so only strict compares move entries.
            while (pos > 0 && (ascending ? held_values[pos-1] > v : held_values[pos-1] < v))
            begin
                held_values[pos] = held_values[pos-1];
                pos--;
            end
            held_values[pos] = v;
            held_count++;
        end
        if (last)
        begin
            for (int k = 0; k < held_count; k++)
            begin
                beat.value         = held_values[k];
                beat.final_of_run  = (k == held_count - 1);
                beat.overflow_seen = dropped;
                pending_sorted.push_back(beat);
            end
            held_count = 0;
            dropped    = 1'b0;
        end
    endfunction

    function void check_result(ibs_pkg::value_t v, logic fin, logic ovf);
        sorted_beat_t exp;
        if (pending_sorted.size() == 0)
        begin
            $display("%0t: result beat with none expected: value %0d final %b overflow %b",
                     $time, v, fin, ovf);
            errors++;
            return;
        end
        exp = pending_sorted.pop_front();
        if (exp.value !== v || exp.final_of_run !== fin || exp.overflow_seen !== ovf)
        begin
            $display("%0t: expected value %0d final %b overflow %b, got value %0d final %b overflow %b",
                     $time, exp.value, exp.final_of_run, exp.overflow_seen, v, fin, ovf);
            errors++;
        end
    endfunction

    function void report_leftover();
        if (pending_sorted.size() != 0)
        begin
            $display("%0t: %0d result beats never arrived, first expected value %0d",
                     $time, pending_sorted.size(), pending_sorted[0].value);
            errors++;
        end
    endfunction
endclass

module integer_batch_sorter_unit_test;

    logic clk;
    logic rst_n;
    int   tx_idle_pct;
    int   rx_idle_pct;

    batch_sort_scoreboard sorter;

    ibs_in_if  sample_ch ();
    ibs_out_if result_ch ();
    ibs_cfg_if cfg_ch ();

    integer_batch_sorter_unit u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (sample_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    initial
    begin
        #5_000_000;
        $display("integer_batch_sorter_unit: mismatch");
        $finish;
    end

    always @(negedge clk)
    begin
        result_ch.ready <= rst_n && ($urandom_range(99) >= rx_idle_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            sorter.check_result(result_ch.sorted_value, result_ch.final_of_run,
                                result_ch.overflow_seen);
        end
    end

    function automatic ibs_pkg::value_t extreme_value(input int idx);
        case (idx)
            0: return 32'sh8000_0000;
            1: return 32'sh7fff_ffff;
            2: return '0;
            3: return '1;
            4: return 32'sd1;
            5: return 32'sh8000_0001;
            default: return 32'sh7fff_fffe;
        endcase
    endfunction

    // Mostly full-range values, with a share of tiny ones so that equal values are common.
    function automatic ibs_pkg::value_t pick_value();
        int r;
        r = $urandom_range(99);
        if (r < 60)
            return ibs_pkg::value_t'($urandom);
        if (r < 85)
            return ibs_pkg::value_t'(int'($urandom_range(6)) - 3);
        return extreme_value($urandom_range(6));
    endfunction

    // Called at a falling edge; returns at the falling edge after the beat is taken.
    task automatic send_sample(input ibs_pkg::value_t v, input bit last);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            sample_ch.valid <= 1'b0;
            @(negedge clk);
        end
        sample_ch.valid        <= 1'b1;
        sample_ch.sample_value <= v;
        sample_ch.batch_end    <= last;
        @(posedge clk);
        while (!sample_ch.ready)
            @(posedge clk);
        sorter.note_sample(v, last);
        @(negedge clk);
    endtask

    task automatic drain_and_settle();
        sample_ch.valid <= 1'b0;
        while (sorter.pending() != 0)
            @(negedge clk);
        // Leave idle cycles before the next step.
        repeat (4) @(negedge clk);
    endtask

    task automatic write_order(input bit asc);
        drain_and_settle();
        cfg_ch.valid           <= 1'b1;
        cfg_ch.ascending_order <= asc;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        sorter.set_order(asc);
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // A nonzero flip_at rewrites the order register partway through the batch.
    task automatic send_batch(input int len, input int flip_at);
        for (int i = 0; i < len; i++)
        begin
            if (i == flip_at && i != 0)
                write_order($urandom_range(1));
            send_sample(pick_value(), i == len - 1);
        end
    endtask

    task automatic random_phase(input int item_goal);
        int sent;
        int len;
        int pick;
        int flip_at;
        sent = 0;
        while (sent < item_goal)
        begin
            pick = $urandom_range(99);
            if (pick < 3)
                len = $urandom_range(70, 60);
            else if (pick < 20)
                len = $urandom_range(24, 9);
            else
                len = $urandom_range(8, 1);
            flip_at = 0;
            if (len > 1 && $urandom_range(9) == 0)
                flip_at = $urandom_range(len - 1, 1);
            if ($urandom_range(9) == 0)
                write_order($urandom_range(1));
            else if ($urandom_range(9) == 0)
                drain_and_settle();
            send_batch(len, flip_at);
            sent += len;
        end
    endtask

    initial
    begin
        int settle_cycles;

        sorter                 = new();
        tx_idle_pct            = 33;
        rx_idle_pct            = 68;
        rst_n                  = 1'b0;
        sample_ch.valid        = 1'b0;
        sample_ch.sample_value = '0;
        sample_ch.batch_end    = 1'b0;
        cfg_ch.valid           = 1'b0;
        cfg_ch.ascending_order = 1'b1;
        result_ch.ready        = 1'b0;
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        write_order(1'b1);
        send_sample(extreme_value(0), 1'b1);
        for (int i = 0; i < 7; i++)
            send_sample(extreme_value(i), i == 6);
        send_sample(32'sd5, 1'b0);
        send_sample(32'sd5, 1'b0);
        send_sample(-32'sd5, 1'b0);
        send_sample(32'sd5, 1'b1);

        write_order(1'b0);
        for (int i = 0; i < 7; i++)
            send_sample(extreme_value(6 - i), i == 6);

        // Values held before the order flips keep their places.
        send_sample(32'sd3, 1'b0);
        send_sample(32'sd1, 1'b0);
        send_sample(32'sd2, 1'b0);
        write_order(1'b1);
        send_sample(32'sd0, 1'b0);
        send_sample(32'sd5, 1'b1);

        // Overfill the store; the batch_end beat itself is one of the dropped ones.
        send_batch(ibs_pkg::MAX_ITEMS + 2, 0);

        write_order(1'b0);
        random_phase(22);

        tx_idle_pct = 68;
        rx_idle_pct = 33;
        write_order(1'b1);
        random_phase(22);

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        write_order($urandom_range(1));
        random_phase(22);

        sample_ch.valid <= 1'b0;
        settle_cycles = 0;
        while (sorter.pending() != 0 && settle_cycles < 20000)
        begin
            @(negedge clk);
            settle_cycles++;
        end
        repeat (80) @(negedge clk);
        sorter.report_leftover();

        if (sorter.errors == 0)
            $display("integer_batch_sorter_unit: match");
        else
            $display("integer_batch_sorter_unit: mismatch");
        $finish;
    end

endmodule

[filelist.f]
rtl/ibs_pkg.sv
rtl/ibs_if.sv
rtl/ibs_cell.sv
rtl/ibs_scan.sv
rtl/integer_batch_sorter_unit.sv
bench/integer_batch_sorter_unit_test.sv
